[src/pkht_pkg.sv]
package pkht_pkg;

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 8;
    localparam int HASH_W     = 32;
    localparam int SLOT_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;
    localparam int HEAP_TOP_W = 17;
    localparam int ROUND_W    = 9;
    localparam int SIZE_CODES = 256;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_MISS     = 3'd2,
        ST_LOAD     = 3'd3,
        ST_DATA     = 3'd4
    } t_status;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_HOLD
    } t_front_state;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_RESOLVE
    } t_back_state;

    // hashed request handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] value_size;
        logic [HASH_W-1:0] hash;
    } t_req;

    // one finished result
    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] data_offset;
    } t_res;

    // one table entry
    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [OFFSET_W-1:0] offset;
    } t_entry;

endpackage

[src/pointer_keyed_open_hash_table_core.sv]
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-------------------------------------
// request   | in        | push / full, taken push & !full | i_kind, i_key, i_value_size
// result    | out       | empty / pop, taken pop & !empty | o_status, o_slot, o_data_offset
//
// the front hashes one key byte a cycle: the hash unit mixes four key bytes of a request, then
// holds it until the request queue takes it
// the back reads the table through its single read port, a read state and a check state per
// probe, after an idle state that takes a request and before a resolve state that pushes the result
// after reset the back clears the table at one entry a cycle, all TABLE_ENTRIES entries, with
// full held high
// two-entry queues sit between front and back and in front of the result port, so a held
// result stalls neither hashing nor the next probe search
module pointer_keyed_open_hash_table_core #(
    parameter int TABLE_ENTRIES = 256,
    parameter int DATA_BYTES    = 65536,
    parameter int ALIGN_BYTES   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_kind,
    input  logic [pkht_pkg::KEY_W-1:0]     i_key,
    input  logic [pkht_pkg::SIZE_W-1:0]    i_value_size,
    output logic                           empty,
    input  logic                           pop,
    output logic [pkht_pkg::STATUS_W-1:0]  o_status,
    output logic [pkht_pkg::SLOT_W-1:0]    o_slot,
    output logic [pkht_pkg::OFFSET_W-1:0]  o_data_offset
);
    import pkht_pkg::*;

    // front to request queue
    logic  w_fq_push;
    t_req  w_fq_data;
    logic  w_fq_full;
    // request queue to back
    logic  w_bq_empty;
    t_req  w_bq_data;
    logic  w_bq_pop;
    // back to result queue
    logic  w_res_push;
    t_res  w_res_data;
    logic  w_res_full;
    t_res  w_out;
    // table clear finished
    logic  w_ready;

    // hash unit: takes a transaction and mixes key bits 33..2
    pkht_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (w_ready),
        .i_push       (push),
        .o_full       (full),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value_size (i_value_size),
        .o_q_push     (w_fq_push),
        .o_q_data     (w_fq_data),
        .i_q_full     (w_fq_full)
    );

    // hashed requests waiting for the probe engine
    pkht_fifo #(
        .WIDTH ($bits(t_req))
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_fq_data),
        .o_full  (w_fq_full),
        .i_pop   (w_bq_pop),
        .o_empty (w_bq_empty),
        .o_data  (w_bq_data)
    );

    // probe engine: owns the table memory, entry count and data end
    pkht_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DATA_BYTES    (DATA_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_ready    (w_ready),
        .i_q_empty  (w_bq_empty),
        .i_q_data   (w_bq_data),
        .o_q_pop    (w_bq_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_data (w_res_data)
    );

    // finished results, oldest on the output ports
    pkht_fifo #(
        .WIDTH ($bits(t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out)
    );

    assign o_status      = w_out.status;
    assign o_slot        = w_out.slot;
    assign o_data_offset = w_out.data_offset;

endmodule

[src/pkht_fifo.sv]
module pkht_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    // two entries
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/pkht_front.sv]
module pkht_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_enable,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_kind,
    input  logic [pkht_pkg::KEY_W-1:0]   i_key,
    input  logic [pkht_pkg::SIZE_W-1:0]  i_value_size,
    output logic                         o_q_push,
    output pkht_pkg::t_req               o_q_data,
    input  logic                         i_q_full
);
    import pkht_pkg::*;

    t_front_state      r_state;
    t_front_state      n_state;
    logic [1:0]        r_byte;
    logic [HASH_W-1:0] r_hash;
    t_kind             r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [SIZE_W-1:0] r_size;
    logic              w_accept;

    // one-at-a-time mixing of one byte
    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b
    );
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] s;
        a = h + HASH_W'(b);
        s = a + (a << 10);
        return s ^ (s >> 6);
    endfunction

    assign w_accept = i_push && !o_full;

    always_comb begin
        o_full   = 1'b0;
        o_q_push = 1'b0;
        case (r_state)
            FR_IDLE: o_full = !i_enable;
            FR_HASH: o_full = 1'b1;
            FR_HOLD: begin
                o_q_push = !i_q_full;
                o_full   = !i_enable || i_q_full;
            end
            default: o_full = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: if (w_accept) n_state = FR_HASH;
            FR_HASH: if (r_byte == 2'd3) n_state = FR_HOLD;
            FR_HOLD: begin
                if (!i_q_full) begin
                    n_state = w_accept ? FR_HASH : FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_key;
            r_size <= i_value_size;
            r_hash <= '0;
            r_byte <= 2'd0;
        end else if (r_state == FR_HASH) begin
            r_hash <= mix_byte(r_hash, r_key[2 + 8*r_byte +: 8]);
            r_byte <= r_byte + 2'd1;
        end
    end

    always_comb begin
        o_q_data            = '0;
        o_q_data.kind       = r_kind;
        o_q_data.key        = r_key;
        o_q_data.value_size = r_size;
        o_q_data.hash       = r_hash;
    end

endmodule

[src/pkht_back.sv]
module pkht_back #(
    parameter int TABLE_ENTRIES = 256,
    parameter int DATA_BYTES    = 65536,
    parameter int ALIGN_BYTES   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output logic            o_ready,
    input  logic            i_q_empty,
    input  pkht_pkg::t_req  i_q_data,
    output logic            o_q_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output pkht_pkg::t_res  o_res_data
);
    import pkht_pkg::*;

    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int PROBE_MAX  = TABLE_ENTRIES + 64;
    localparam int PROBE_W    = $clog2(PROBE_MAX);
    localparam int LOAD_LIMIT = TABLE_ENTRIES * 3;

    t_back_state           r_state;
    t_back_state           n_state;
    t_entry                r_mem [TABLE_ENTRIES];
    t_entry                r_rd;
    logic [IDX_W-1:0]      r_clr_idx;
    t_req                  r_req;
    logic [IDX_W-1:0]      r_ix;
    logic [HASH_W-1:0]     r_step;
    logic [PROBE_W-1:0]    r_n;
    logic                  r_ok;
    logic                  r_hit;
    logic [OFFSET_W-1:0]   r_hit_offset;
    logic [COUNT_W-1:0]    r_count;
    logic [HEAP_TOP_W-1:0] r_heap_top;

    logic                  w_stop;
    logic                  w_last;
    logic [IDX_W-1:0]      w_next_ix;
    logic                  w_load_high;
    logic                  w_data_over;
    t_status               w_status;
    logic                  w_insert;
    logic                  w_we;
    logic [IDX_W-1:0]      w_addr;
    t_entry                w_wdata;
    logic [ROUND_W-1:0]    w_round [SIZE_CODES];

    // size rounded up to the alignment, one entry per size code
    for (genvar g = 0; g < SIZE_CODES; g++) begin : g_round
        assign w_round[g] =
            ROUND_W'(((g + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
    end

    assign w_stop      = !r_rd.valid || (r_rd.key == r_req.key);
    assign w_last      = (r_n == PROBE_W'(PROBE_MAX - 1));
    assign w_next_ix   = r_ix + r_step[IDX_W-1:0];
    assign w_load_high = ((32'(r_count) << 2) > 32'(LOAD_LIMIT));
    assign w_data_over = ((32'(r_heap_top) + 32'(r_req.value_size)) > 32'(DATA_BYTES));

    always_comb begin
        if (r_hit) begin
            w_status = ST_FOUND;
        end else if (r_req.kind == KIND_LOOKUP) begin
            w_status = ST_MISS;
        end else if (!r_ok || w_load_high) begin
            w_status = ST_LOAD;
        end else if (w_data_over) begin
            w_status = ST_DATA;
        end else begin
            w_status = ST_INSERTED;
        end
    end

    always_comb begin
        o_ready    = (r_state != BK_CLEAR);
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        w_insert   = 1'b0;
        w_we       = 1'b0;
        w_addr     = r_ix;
        w_wdata    = '0;
        o_res_data = '0;
        case (r_state)
            BK_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr_idx;
            end
            BK_IDLE: o_q_pop = !i_q_empty;
            BK_RESOLVE: begin
                o_res_push             = !i_res_full;
                w_insert               = !i_res_full && (w_status == ST_INSERTED);
                w_we                   = w_insert;
                w_wdata.valid          = 1'b1;
                w_wdata.key            = r_req.key;
                w_wdata.offset         = r_heap_top[OFFSET_W-1:0];
                o_res_data.status      = w_status;
                o_res_data.slot        = SLOT_W'(r_ix);
                if (w_status == ST_FOUND) begin
                    o_res_data.data_offset = r_hit_offset;
                end else if (w_status == ST_INSERTED) begin
                    o_res_data.data_offset = r_heap_top[OFFSET_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR:   if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) n_state = BK_IDLE;
            BK_IDLE:    if (!i_q_empty) n_state = BK_READ;
            BK_READ:    n_state = BK_CHECK;
            BK_CHECK:   n_state = (w_stop || w_last) ? BK_RESOLVE : BK_READ;
            BK_RESOLVE: if (!i_res_full) n_state = BK_IDLE;
            default:    n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_idx  <= '0;
            r_count    <= '0;
            r_heap_top <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (w_insert) begin
                r_count    <= r_count + COUNT_W'(1);
                r_heap_top <= r_heap_top + HEAP_TOP_W'(w_round[r_req.value_size]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_req  <= i_q_data;
                r_ix   <= i_q_data.hash[IDX_W-1:0];
                r_step <= i_q_data.hash;
                r_n    <= '0;
            end
            BK_CHECK: begin
                r_hit_offset <= r_rd.offset;
                if (w_stop) begin
                    r_ok  <= 1'b1;
                    r_hit <= r_rd.valid;
                end else begin
                    r_ok   <= 1'b0;
                    r_hit  <= 1'b0;
                    r_ix   <= w_next_ix;
                    r_step <= (r_step >> 5) + HASH_W'(1);
                    r_n    <= r_n + PROBE_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rd <= r_mem[r_ix];
    end

endmodule

[src/pkht_checker.sv]
module pkht_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [pkht_pkg::STATUS_W-1:0]  o_status,
    input logic [pkht_pkg::SLOT_W-1:0]    o_slot,
    input logic [pkht_pkg::OFFSET_W-1:0]  o_data_offset
);
    import pkht_pkg::*;

    // no transaction comes out of reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // table clear holds off requests
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("request taken during table clear");

    // offset only reported for found or inserted keys
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_MISS || o_status == ST_LOAD || o_status == ST_DATA))
        |-> (o_data_offset == '0))
        else $error("nonzero offset on a refused or missed key");

    // defined status codes only
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == ST_FOUND || o_status == ST_INSERTED ||
                    o_status == ST_MISS || o_status == ST_LOAD || o_status == ST_DATA))
        else $error("undefined status code");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_slot) &&
                              $stable(o_data_offset)))
        else $error("waiting result changed");

endmodule

bind pointer_keyed_open_hash_table_core pkht_checker u_pkht_checker (.*);
